FILE: design/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define SC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// expression must never be true outside reset
`define SC_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define SC_ASSERT(lbl, clk, rst, prop)
`define SC_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

FILE: design/scfifo_pkg.sv
// types, codes and keymap tables for the scancode translator
package scfifo_pkg;

   // special scancodes
   localparam logic [7:0] KEY_LSHIFT    = 8'h2A;
   localparam logic [7:0] KEY_RSHIFT    = 8'h36;
   localparam logic [7:0] KEY_LSHIFT_UP = 8'hAA;
   localparam logic [7:0] KEY_RSHIFT_UP = 8'hB6;
   localparam logic [7:0] KEY_CAPS      = 8'h3A;
   localparam logic [7:0] BREAK_BIT     = 8'h80;
   localparam logic [7:0] MAP_LEN       = 8'h54;
   localparam int         MAP_ENTRIES   = 84;

   localparam int CHAR_W = 7;

   // us layout, unshifted
   localparam logic [CHAR_W-1:0] PLAIN_MAP [0:MAP_ENTRIES-1] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
      7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
      7'h32, 7'h33, 7'h30, 7'h2E
   };

   // us layout, shifted
   localparam logic [CHAR_W-1:0] UPPER_MAP [0:MAP_ENTRIES-1] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
      7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
      7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
      7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
      7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
      7'h32, 7'h33, 7'h30, 7'h2E
   };

   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'h7A;

   // translator result handed to the buffer control
   typedef struct packed {
      logic              has_char;
      logic [CHAR_W-1:0] char_code;
   } xlate_result_type;

endpackage

FILE: design/scancode_to_ascii_fifo_top.sv
// top level: scancode translator feeding a character ring buffer
//
// Input channel req_*: each item is either a push of one set 1 scancode
// byte or a pop of the oldest buffered character. Result channel rsp_*:
// exactly one result item per input item, in order.
// A push updates the shift and caps lock state, translates the code and
// appends the character when there is one; a full buffer drops it. A pop
// returns the oldest character, or char_valid = 0 when the buffer is empty.
// Each item passes stage 1, which waits for the registered memory read,
// and then the output register. Throughput: one item per cycle while
// the receiver does not stall, set by the single write and single read
// port of the character memory. A pop never reads the entry written in the
// same cycle, so no forwarding is needed.
// When rsp_tready is low the output register holds its item and the
// pipeline stage in front of it keeps one more; req_tready drops once both
// are occupied. Reset empties the buffer and clears both modifiers; no
// memory clearing pass is needed. The buffer holds FIFO_DEPTH-1 characters.
`include "assert_macros.svh"
module scancode_to_ascii_fifo_top
   import scfifo_pkg::*;
#(
   parameter int FIFO_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] command, [8:1] scancode, [15:9] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] char_valid, [7:1] char_out, [8] stored,
                                    // [9] dropped, [10] buffer_empty, [15:11] zero
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   logic             accept;
   logic             cmd;
   logic [7:0]       code;
   xlate_result_type xres;
   logic             push_en;
   logic             do_pop;
   logic             do_store;
   logic             do_drop;
   logic             buf_empty;
   logic             buf_full;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_next;
   logic [CHAR_W-1:0] rd_data;

   logic s1_valid_ff, s1_valid_in;
   logic s1_popped_ff, s1_stored_ff, s1_dropped_ff, s1_empty_ff;
   logic s1_adv;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_char_valid_ff;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic              rsp_stored_ff, rsp_dropped_ff, rsp_empty_ff;

   // handshake: output register frees the pipeline stage, stage frees the input
   assign s1_adv     = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = req_tdata[0];
   assign code       = req_tdata[8:1];

   assign push_en = accept && (cmd == CMD_PUSH);

   scfifo_xlate u_xlate (
      .clock   (clock),
      .reset   (reset),
      .push_en (push_en),
      .code    (code),
      .result  (xres)
   );

   // buffer control
   always_comb begin
      wr_next   = advance(wr_ptr_ff);
      buf_empty = (wr_ptr_ff == rd_ptr_ff);
      buf_full  = (wr_next == rd_ptr_ff);
      do_pop    = accept && (cmd == CMD_POP) && !buf_empty;
      do_store  = push_en && xres.has_char && !buf_full;
      do_drop   = push_en && xres.has_char && buf_full;
      wr_ptr_in = do_store ? wr_next : wr_ptr_ff;
      rd_ptr_in = do_pop ? advance(rd_ptr_ff) : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   scfifo_store #(
      .DEPTH (FIFO_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_store),
      .wr_addr (wr_ptr_ff),
      .wr_data (xres.char_code),
      .rd_en   (do_pop),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // stage 1: waits for the memory read
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_popped_ff  <= do_pop;
         s1_stored_ff  <= do_store;
         s1_dropped_ff <= do_drop;
         s1_empty_ff   <= (wr_ptr_in == rd_ptr_in);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff) begin
         rsp_char_valid_ff <= s1_popped_ff;
         rsp_char_ff       <= s1_popped_ff ? rd_data : '0;
         rsp_stored_ff     <= s1_stored_ff;
         rsp_dropped_ff    <= s1_dropped_ff;
         rsp_empty_ff      <= s1_empty_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_empty_ff, rsp_dropped_ff, rsp_stored_ff,
                        rsp_char_ff, rsp_char_valid_ff};

   // checks
   `SC_ASSERT_NEVER(a_wr_ptr_range, clock, reset, wr_ptr_ff > PTR_LAST)
   `SC_ASSERT_NEVER(a_rd_ptr_range, clock, reset, rd_ptr_ff > PTR_LAST)
   `SC_ASSERT_NEVER(a_pop_push_mix, clock, reset,
      rsp_valid_ff && rsp_char_valid_ff && (rsp_stored_ff || rsp_dropped_ff))
   `SC_ASSERT(a_pop_advances, clock, reset,
      do_pop |=> (rd_ptr_ff != $past(rd_ptr_ff)))

endmodule

FILE: design/scfifo_xlate.sv
// modifier tracking and scancode to ascii lookup
module scfifo_xlate
   import scfifo_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push_en,
   input  logic [7:0]       code,
   output xlate_result_type result
);

   logic shift_down_ff, shift_down_in;
   logic caps_on_ff, caps_on_in;
   logic [6:0] map_idx;
   logic [CHAR_W-1:0] base_char;
   logic [CHAR_W-1:0] upper_char;
   logic in_map;
   logic use_upper;
   logic is_modifier;

   // table lookup with current modifier state
   always_comb begin
      in_map     = (code < MAP_LEN);
      map_idx    = code[6:0];
      base_char  = in_map ? PLAIN_MAP[map_idx] : '0;
      upper_char = in_map ? UPPER_MAP[map_idx] : '0;
      if (base_char >= CHAR_LOWER_A && base_char <= CHAR_LOWER_Z) begin
         use_upper = caps_on_ff ^ shift_down_ff;
      end else begin
         use_upper = shift_down_ff;
      end
      is_modifier = (code == KEY_LSHIFT) || (code == KEY_RSHIFT) || (code == KEY_CAPS);
      result.char_code = use_upper ? upper_char : base_char;
      result.has_char  = !is_modifier && ((code & BREAK_BIT) == 8'h00)
                         && (result.char_code != '0);
   end

   // modifier updates
   always_comb begin
      shift_down_in = shift_down_ff;
      caps_on_in    = caps_on_ff;
      if (push_en) begin
         if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
            shift_down_in = 1'b1;
         end else if (code == KEY_LSHIFT_UP || code == KEY_RSHIFT_UP) begin
            shift_down_in = 1'b0;
         end else if (code == KEY_CAPS) begin
            caps_on_in = !caps_on_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_down_ff <= 1'b0;
         caps_on_ff    <= 1'b0;
      end else begin
         shift_down_ff <= shift_down_in;
         caps_on_ff    <= caps_on_in;
      end
   end

endmodule

FILE: design/scfifo_store.sv
// character ring memory, one write and one registered read port
module scfifo_store
   import scfifo_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [CHAR_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [CHAR_W-1:0]        rd_data
);

   logic [CHAR_W-1:0] mem [0:DEPTH-1];
   logic [CHAR_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/tb_scancode_to_ascii_fifo_top.sv
// self-checking testbench: key pushes and character pops against a keyboard buffer model
module tb_scancode_to_ascii_fifo_top;

   localparam int BUF_DEPTH = 256;
   localparam int MAP_SIZE  = 84;
   localparam int RANDOM_ITEMS = 1450;

   // special scancodes seen by the translator
   localparam logic [7:0] LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] RSHIFT_BREAK = 8'hB6;
   localparam logic [7:0] CAPS_MAKE    = 8'h3A;
   localparam logic [7:0] EXT_PREFIX   = 8'hE0;
   localparam logic [7:0] BREAK_FLAG   = 8'h80;

   typedef enum logic {CMD_PUSH = 1'b0, CMD_POP = 1'b1} kbd_cmd_type;

   // rsp_tdata layout, msb first
   typedef struct packed {
      logic [4:0] pad;
      logic       buffer_empty;
      logic       dropped;
      logic       stored;
      logic [6:0] char_out;
      logic       char_valid;
   } kbd_reply_type;

   typedef struct {
      kbd_cmd_type cmd;
      logic [7:0]  code;
      bit          hold;   // wait for every outstanding reply before sending
   } keystroke_type;

   // us keymap, no modifier
   localparam logic [6:0] US_PLAIN [0:MAP_SIZE-1] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
      7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
      7'h32, 7'h33, 7'h30, 7'h2E
   };

   // us keymap, shifted
   localparam logic [6:0] US_SHIFTED [0:MAP_SIZE-1] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
      7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
      7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
      7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
      7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
      7'h32, 7'h33, 7'h30, 7'h2E
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [0] command, [8:1] scancode, [15:9] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [0] char_valid, [7:1] char_out, [8] stored,
                                  // [9] dropped, [10] buffer_empty, [15:11] zero

   // keyboard state as the block should hold it
   bit         shift_active;
   bit         caps_lock;
   logic [6:0] typed_chars [$];

   keystroke_type keystroke_q [$];
   kbd_reply_type awaited_replies [$];
   keystroke_type cur_key;
   int            gap_left;
   int            burst_left;
   int            stall_mode;
   int            mode_left;
   bit            ready_next;
   kbd_reply_type got_reply;
   kbd_reply_type want_reply;
   int            replies_checked;
   int            total_keys;
   int            errors;

   scancode_to_ascii_fifo_top #(
      .FIFO_DEPTH (BUF_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // expected reply for one item, advancing the keyboard state
   function automatic kbd_reply_type kbd_translate_step(input kbd_cmd_type cmd,
                                                        input logic [7:0] code);
      kbd_reply_type r;
      logic [6:0] base;
      logic [6:0] ch;
      bit         upper;
      r = '0;
      ch = '0;
      if (cmd == CMD_POP) begin
         if (typed_chars.size() > 0) begin
            r.char_valid = 1'b1;
            r.char_out = typed_chars.pop_front();
         end
      end else if (code == LSHIFT_MAKE || code == RSHIFT_MAKE) begin
         shift_active = 1'b1;
      end else if (code == LSHIFT_BREAK || code == RSHIFT_BREAK) begin
         shift_active = 1'b0;
      end else if (code == CAPS_MAKE) begin
         caps_lock = !caps_lock;
      end else if ((code & BREAK_FLAG) == 8'h00) begin
         if (code < MAP_SIZE) begin
            base = US_PLAIN[code[6:0]];
            // caps lock only affects letters
            if (base >= 7'h61 && base <= 7'h7A)
               upper = caps_lock ^ shift_active;
            else
               upper = shift_active;
            ch = upper ? US_SHIFTED[code[6:0]] : base;
         end
         if (ch != 7'h00) begin
            if (typed_chars.size() == BUF_DEPTH - 1) begin
               r.dropped = 1'b1;
            end else begin
               typed_chars.push_back(ch);
               r.stored = 1'b1;
            end
         end
      end
      r.buffer_empty = (typed_chars.size() == 0);
      return r;
   endfunction

   // a make code that yields a character
   function automatic logic [7:0] char_key_code();
      logic [7:0] code;
      code = 8'($urandom_range(0, MAP_SIZE - 1));
      while (US_PLAIN[code[6:0]] == 7'h00)
         code = 8'($urandom_range(0, MAP_SIZE - 1));
      return code;
   endfunction

   // mostly typing, with modifiers, prefixes, releases and raw noise
   function automatic logic [7:0] typing_code();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60) return char_key_code();
      if (sel < 70) return $urandom_range(0, 1) ? LSHIFT_MAKE : RSHIFT_MAKE;
      if (sel < 78) return $urandom_range(0, 1) ? LSHIFT_BREAK : RSHIFT_BREAK;
      if (sel < 82) return CAPS_MAKE;
      if (sel < 88) return EXT_PREFIX;
      if (sel < 94) return char_key_code() | BREAK_FLAG;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic add_key(input kbd_cmd_type cmd, input logic [7:0] code, input bit hold);
      keystroke_type k;
      k.cmd = cmd;
      k.code = code;
      k.hold = hold;
      keystroke_q.push_back(k);
   endtask

   // driver: bursts of items separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         gap_left = 0;
         burst_left = 0;
      end else begin
         if (req_tvalid && req_tready)
            awaited_replies.push_back(kbd_translate_step(cur_key.cmd, cur_key.code));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (keystroke_q.size() > 0 &&
                         !(keystroke_q[0].hold && awaited_replies.size() > 0)) begin
               cur_key = keystroke_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {7'b0, cur_key.code, cur_key.cmd};
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result item, receiver stalls in changing modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_mode = 0;
         mode_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_reply = kbd_reply_type'(rsp_tdata);
            if (awaited_replies.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_tdata);
               errors++;
            end else begin
               want_reply = awaited_replies.pop_front();
               replies_checked++;
               if (got_reply !== want_reply) begin
                  $display("%0t: result mismatch, expected %h, got %h",
                           $time, want_reply, got_reply);
                  errors++;
               end
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: ready_next = 1'b1;
            1: ready_next = 1'($urandom_range(0, 1));
            2: ready_next = ($urandom_range(0, 3) == 0);
            default: ready_next = !rsp_tready;
         endcase
         rsp_tready <= ready_next;
      end
   end

   initial begin
      int seg_len;
      int push_pct;
      int n;
      shift_active = 1'b0;
      caps_lock = 1'b0;
      replies_checked = 0;
      errors = 0;

      // directed: empty pop, modifiers, ignored codes, table edges
      add_key(CMD_POP,  8'h00, 1'b0);
      add_key(CMD_PUSH, 8'h00, 1'b0);          // zero table entry
      add_key(CMD_PUSH, 8'h01, 1'b0);          // escape, no character
      add_key(CMD_PUSH, 8'h1E, 1'b0);
      add_key(CMD_PUSH, 8'h02, 1'b0);
      add_key(CMD_PUSH, LSHIFT_MAKE, 1'b0);
      add_key(CMD_PUSH, 8'h1E, 1'b0);
      add_key(CMD_PUSH, 8'h02, 1'b0);
      add_key(CMD_PUSH, 8'h35, 1'b0);
      add_key(CMD_PUSH, LSHIFT_BREAK, 1'b0);
      add_key(CMD_PUSH, CAPS_MAKE, 1'b0);
      add_key(CMD_PUSH, 8'h1E, 1'b0);
      add_key(CMD_PUSH, 8'h02, 1'b0);
      add_key(CMD_PUSH, RSHIFT_MAKE, 1'b0);
      add_key(CMD_PUSH, 8'h2C, 1'b0);          // caps and shift cancel on letters
      add_key(CMD_PUSH, 8'h0C, 1'b0);
      add_key(CMD_PUSH, RSHIFT_BREAK, 1'b0);
      add_key(CMD_PUSH, CAPS_MAKE | BREAK_FLAG, 1'b0);   // caps release ignored
      add_key(CMD_PUSH, EXT_PREFIX, 1'b0);
      add_key(CMD_PUSH, 8'h9E, 1'b0);
      add_key(CMD_PUSH, 8'hFF, 1'b0);
      add_key(CMD_PUSH, 8'h53, 1'b0);          // last table entry
      add_key(CMD_PUSH, 8'h54, 1'b0);          // past the table
      add_key(CMD_PUSH, 8'h7F, 1'b0);
      add_key(CMD_PUSH, CAPS_MAKE, 1'b0);
      add_key(CMD_POP,  8'hFF, 1'b0);

      // fill past capacity so characters get dropped, after all outstanding replies
      for (int i = 0; i < 300; i++) begin
         n = $urandom_range(0, 99);
         if (n < 3)
            add_key(CMD_PUSH, $urandom_range(0, 1) ? LSHIFT_MAKE : RSHIFT_MAKE, i == 0);
         else if (n < 6)
            add_key(CMD_PUSH, $urandom_range(0, 1) ? LSHIFT_BREAK : RSHIFT_BREAK, i == 0);
         else
            add_key(CMD_PUSH, char_key_code(), i == 0);
      end
      // mostly pops to drain the buffer, with some typing mixed in
      for (int i = 0; i < 290; i++) begin
         if ($urandom_range(0, 9) == 0)
            add_key(CMD_PUSH, typing_code(), 1'b0);
         else
            add_key(CMD_POP, 8'($urandom_range(0, 255)), 1'b0);
      end

      // mixed typing and reading at varying balance
      while (keystroke_q.size() < RANDOM_ITEMS - 40) begin
         seg_len = $urandom_range(40, 120);
         case ($urandom_range(0, 2))
            0: push_pct = 30;
            1: push_pct = 55;
            default: push_pct = 80;
         endcase
         for (int i = 0; i < seg_len; i++) begin
            if ($urandom_range(1, 100) <= push_pct)
               add_key(CMD_PUSH, typing_code(), i == 0 && $urandom_range(0, 2) == 0);
            else
               add_key(CMD_POP, 8'($urandom_range(0, 255)), i == 0 && $urandom_range(0, 2) == 0);
         end
      end
      total_keys = keystroke_q.size();

      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (replies_checked < total_keys)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0 && awaited_replies.size() == 0)
         $display("scancode_to_ascii_fifo_top test passed");
      else
         $display("scancode_to_ascii_fifo_top test failed");
      $finish;
   end

   // watchdog
   initial begin
      #3000000;
      $display("scancode_to_ascii_fifo_top test failed");
      $finish;
   end

endmodule
